>>> design/tbo_pkg.sv
// package for the triangle/box overlap unit
// shared widths and register indexes; no dependencies
package tbo_pkg;
	localparam int COORD_BITS_DEF = 20;
	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} cfg_reg_t;
endpackage

>>> design/tbo_if.sv
// valid/ready channel interfaces for the triangle/box overlap unit
// depends on nothing but its parameter
interface tbo_tri_if #(parameter int COORD_BITS = 20);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
	logic mesh_last_in;
	modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
		mesh_last_in, input ready);
	modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
		mesh_last_in, output ready);
endinterface

interface tbo_res_if;
	logic valid;
	logic ready;
	logic overlap;
	logic mesh_last_out;
	modport source (output valid, overlap, mesh_last_out, input ready);
	modport sink (input valid, overlap, mesh_last_out, output ready);
endinterface

>>> design/tbo_axis.sv
// one separating-axis test in three register stages: products, sums, compare
// depends on nothing; the pipeline enable comes from the top level
module tbo_axis #(
	parameter int CW = 24,   // component width of vertices, axis and extents
	parameter int PW = 50    // product/sum width
) (
	input  logic clk,
	input  logic en,
	input  logic signed [CW-1:0] p0 [3],
	input  logic signed [CW-1:0] p1 [3],
	input  logic signed [CW-1:0] p2 [3],
	input  logic signed [CW-1:0] ax [3],
	input  logic signed [CW-1:0] ext [3],
	output logic sep
);
	logic signed [2*CW-1:0] m0_s1 [3], m1_s1 [3], m2_s1 [3], mr_s1 [3];
	logic signed [PW-1:0] d0_s2, d1_s2, d2_s2, r_s2;
	logic signed [CW:0] aabs [3];
	logic signed [PW-1:0] lo, hi;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			aabs[k] = ax[k][CW-1] ? -{ax[k][CW-1], ax[k]} : {ax[k][CW-1], ax[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				m0_s1[k] <= p0[k] * ax[k];
				m1_s1[k] <= p1[k] * ax[k];
				m2_s1[k] <= p2[k] * ax[k];
				mr_s1[k] <= (2*CW)'(ext[k]) * (2*CW)'(aabs[k]);
			end
			d0_s2 <= PW'(m0_s1[0]) + PW'(m0_s1[1]) + PW'(m0_s1[2]);
			d1_s2 <= PW'(m1_s1[0]) + PW'(m1_s1[1]) + PW'(m1_s1[2]);
			d2_s2 <= PW'(m2_s1[0]) + PW'(m2_s1[1]) + PW'(m2_s1[2]);
			r_s2  <= PW'(mr_s1[0]) + PW'(mr_s1[1]) + PW'(mr_s1[2]);
		end
	end

	always_comb begin
		lo = d0_s2;
		hi = d0_s2;
		if (d1_s2 < lo) lo = d1_s2;
		if (d2_s2 < lo) lo = d2_s2;
		if (d1_s2 > hi) hi = d1_s2;
		if (d2_s2 > hi) hi = d2_s2;
	end

	always_ff @(posedge clk) begin
		if (en) sep <= (r_s2 < lo) || (hi < -r_s2);
	end
endmodule

>>> design/tbo_normal.sv
// triangle-plane test: normal, then dot products in halves, then compare
// depends on nothing; five register stages
module tbo_normal #(
	parameter int CW = 24
) (
	input  logic clk,
	input  logic en,
	input  logic signed [CW-1:0] f0 [3],
	input  logic signed [CW-1:0] f1 [3],
	input  logic signed [CW-1:0] p0 [3],
	input  logic signed [CW-1:0] ext [3],
	output logic sep
);
	localparam int NW = 2*CW + 1;
	localparam int HW = (NW + 1) / 2;       // low half of a split normal
	localparam int SW = NW + CW + 3;

	logic signed [2*CW-1:0] a_s1 [3], b_s1 [3];
	logic signed [CW-1:0] p_s1 [3], e_s1 [3];
	logic signed [NW-1:0] n_s2 [3], na_s2 [3];
	logic signed [CW-1:0] p_s2 [3], e_s2 [3];
	logic signed [SW-1:0] sl_s3 [3], sh_s3 [3], rl_s3 [3], rh_s3 [3];
	logic signed [SW-1:0] s_s4, r_s4;
	logic signed [NW-1:0] nn [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nn[k] = NW'(a_s1[k]) - NW'(b_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= f0[1] * f1[2];  b_s1[0] <= f0[2] * f1[1];
			a_s1[1] <= f0[2] * f1[0];  b_s1[1] <= f0[0] * f1[2];
			a_s1[2] <= f0[0] * f1[1];  b_s1[2] <= f0[1] * f1[0];
			p_s1 <= p0;
			e_s1 <= ext;
			for (int k = 0; k < 3; k++) begin
				n_s2[k]  <= nn[k];
				na_s2[k] <= nn[k][NW-1] ? -nn[k] : nn[k];
			end
			p_s2 <= p_s1;
			e_s2 <= e_s1;
			// the normal is split so no multiplier exceeds about 32 bits wide
			for (int k = 0; k < 3; k++) begin
				sl_s3[k] <= SW'($signed({1'b0, n_s2[k][HW-1:0]})) * SW'(p_s2[k]);
				sh_s3[k] <= (SW'($signed(n_s2[k][NW-1:HW])) * SW'(p_s2[k])) <<< HW;
				rl_s3[k] <= SW'($signed({1'b0, na_s2[k][HW-1:0]})) * SW'(e_s2[k]);
				rh_s3[k] <= (SW'($signed(na_s2[k][NW-1:HW])) * SW'(e_s2[k])) <<< HW;
			end
			s_s4 <= sl_s3[0] + sh_s3[0] + sl_s3[1] + sh_s3[1] + sl_s3[2] + sh_s3[2];
			r_s4 <= rl_s3[0] + rh_s3[0] + rl_s3[1] + rh_s3[1] + rl_s3[2] + rh_s3[2];
			sep <= r_s4 < (s_s4[SW-1] ? -s_s4 : s_s4);
		end
	end
endmodule

>>> design/triangle_box_overlap_test_unit.sv
// top level of the triangle/box overlap unit: config registers, front end, pipeline control
// depends on tbo_pkg, tbo_if, tbo_axis and tbo_normal
// Takes one triangle per clock and returns one overlap flag per triangle; the depth
// is set by the plane test (normal, split dot products, sum, compare) after a front-end
// stage that centers the vertices on the box. The whole pipeline advances together and
// holds while the output beat is not taken, so the throughput is one triangle per cycle
// whenever the result side keeps up. The user must see that box registers are written
// only while no triangle is in flight; the block itself does not enforce this.
module triangle_box_overlap_test_unit #(
	parameter int COORD_BITS = tbo_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [tbo_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [COORD_BITS-1:0] cfg_data,
	tbo_tri_if.sink tri_in,
	tbo_res_if.source res_out
);
	localparam int CW = COORD_BITS + 4;
	localparam int PW = 2*CW + 2;
	localparam int DEPTH = 6;

	logic signed [COORD_BITS-1:0] bmin_q [3], bmax_q [3];
	logic [DEPTH-1:0] vld_q;
	logic [DEPTH-1:0] last_q;
	logic en;
	logic signed [CW-1:0] vt_s1 [3][3], ext_s1 [3], f_s1 [3][3];
	logic signed [COORD_BITS-1:0] vin [3][3];
	logic signed [CW-1:0] ax [9][3];
	logic [8:0] sep_ax;
	logic sep_n;
	logic face_hit;
	logic face_s [4];
	logic face_sep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				bmin_q[k] <= '0;
				bmax_q[k] <= '0;
			end
		end else if (cfg_we) begin
			case (tbo_pkg::cfg_reg_t'(cfg_idx))
				tbo_pkg::REG_MIN_X: bmin_q[0] <= cfg_data;
				tbo_pkg::REG_MIN_Y: bmin_q[1] <= cfg_data;
				tbo_pkg::REG_MIN_Z: bmin_q[2] <= cfg_data;
				tbo_pkg::REG_MAX_X: bmax_q[0] <= cfg_data;
				tbo_pkg::REG_MAX_Y: bmax_q[1] <= cfg_data;
				tbo_pkg::REG_MAX_Z: bmax_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en = !res_out.valid || res_out.ready;
	assign tri_in.ready = en;
	assign res_out.valid = vld_q[DEPTH-1];
	assign res_out.mesh_last_out = last_q[DEPTH-1];
	assign res_out.overlap = !(sep_n || face_sep || (|sep_ax));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], tri_in.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) last_q <= {last_q[DEPTH-2:0], tri_in.mesh_last_in};
	end

	assign vin[0] = '{tri_in.v0_x, tri_in.v0_y, tri_in.v0_z};
	assign vin[1] = '{tri_in.v1_x, tri_in.v1_y, tri_in.v1_z};
	assign vin[2] = '{tri_in.v2_x, tri_in.v2_y, tri_in.v2_z};

	// doubled coordinates centered on the box, and full extents
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ext_s1[k] <= CW'(bmax_q[k]) - CW'(bmin_q[k]);
				for (int i = 0; i < 3; i++) begin
					vt_s1[i][k] <= (CW'(vin[i][k]) <<< 1) - CW'(bmin_q[k]) - CW'(bmax_q[k]);
					f_s1[i][k] <= (CW'(vin[(i+1)%3][k]) - CW'(vin[i][k])) <<< 1;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ax[3*i][0]   = '0;          ax[3*i][1]   = -f_s1[i][2]; ax[3*i][2]   = f_s1[i][1];
			ax[3*i+1][0] = f_s1[i][2];  ax[3*i+1][1] = '0;          ax[3*i+1][2] = -f_s1[i][0];
			ax[3*i+2][0] = -f_s1[i][1]; ax[3*i+2][1] = f_s1[i][0];  ax[3*i+2][2] = '0;
		end
	end

	for (genvar g = 0; g < 9; g++) begin : g_axis
		logic sep_a;
		logic [1:0] dly_q;
		tbo_axis #(.CW(CW), .PW(PW)) u_axis (
			.clk(clk), .en(en),
			.p0(vt_s1[0]), .p1(vt_s1[1]), .p2(vt_s1[2]),
			.ax(ax[g]), .ext(ext_s1), .sep(sep_a)
		);
		// line the edge tests up with the deeper plane test
		always_ff @(posedge clk) begin
			if (en) dly_q <= {dly_q[0], sep_a};
		end
		assign sep_ax[g] = dly_q[1];
	end

	tbo_normal #(.CW(CW)) u_normal (
		.clk(clk), .en(en), .f0(f_s1[0]), .f1(f_s1[1]), .p0(vt_s1[0]), .ext(ext_s1),
		.sep(sep_n)
	);

	always_comb begin
		face_hit = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if ((vt_s1[0][k] < -ext_s1[k] && vt_s1[1][k] < -ext_s1[k]
				&& vt_s1[2][k] < -ext_s1[k])
				|| (vt_s1[0][k] > ext_s1[k] && vt_s1[1][k] > ext_s1[k]
				&& vt_s1[2][k] > ext_s1[k]))
				face_hit = 1'b1;
		end
	end

	// box face tests, delayed to match
	always_ff @(posedge clk) begin
		if (en) begin
			face_s[0] <= face_hit;
			face_s[1] <= face_s[0];
			face_s[2] <= face_s[1];
			face_s[3] <= face_s[2];
			face_sep <= face_s[3];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && !res_out.ready |=> res_out.valid && $stable(res_out.overlap))
		else $error("result changed under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		tri_in.ready == (!res_out.valid || res_out.ready))
		else $error("input ready not tied to pipeline enable");
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid bits moved while stalled");
endmodule
